FILE: rtl/core/prf_pkg.sv
// Partition refinement package: beat types, status codes, sequencer states.
// Used by prf_seq and partition_refinement_top; depends on nothing.
package prf_pkg;

  localparam int unsigned ELEM_W = 10;
  localparam int unsigned CNT_W  = 11;
  localparam int unsigned NB_W   = 10;

  localparam int unsigned DEF_MAX_ELEMENTS = 1024;
  localparam int unsigned DEF_MAX_BLOCKS   = 1024;

  localparam logic REQ_RESET  = 1'b0;
  localparam logic REQ_REFINE = 1'b1;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_UNKNOWN = 2'd1,
    ST_NOFREE  = 2'd2
  } status_e;

  typedef struct packed {
    logic              req_type;
    logic [ELEM_W-1:0] element;
    logic              last;
  } in_beat_t;

  typedef struct packed {
    logic [NB_W-1:0]  new_block;
    logic [CNT_W-1:0] block_count;
    logic [1:0]       status;
  } out_beat_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CLEAR,
    S_RD_B,
    S_RD_S,
    S_SCAN_RD,
    S_SCAN_CHK,
    S_ALLOC,
    S_MV_RD,
    S_MV_B,
    S_MV_S,
    S_LAST,
    S_CL_RD,
    S_CL_B,
    S_CL_WR,
    S_DONE
  } seq_state_e;

endpackage

FILE: rtl/core/partition_refinement_top.sv
// Partition refinement top: channels, element_count register, result register.
// Depends on prf_pkg and prf_seq.
//
//  channel | direction | payload    | handshake
//  in      | input     | in_beat_t  | in_valid_i / in_stall_o
//  out     | output    | out_beat_t | out_valid_o / out_stall_i
//  cfg     | input     | 11 bits    | cfg_we_i, no wait
//
// A refine beat whose block already has a split reads the tables, moves the element and
// replies; claiming a new id adds a free-id search that passes each in-use id it meets,
// and a last beat adds a walk over every touched block. An unknown element skips the tables.
// A reset beat and reset itself run a clearing pass over max(MAX_ELEMENTS, MAX_BLOCKS)
// table entries; no input beat is taken during that pass.
// One beat is in work at a time; a finished result waits in the output register.
module partition_refinement_top #(
  parameter int unsigned MAX_ELEMENTS = prf_pkg::DEF_MAX_ELEMENTS,
  parameter int unsigned MAX_BLOCKS   = prf_pkg::DEF_MAX_BLOCKS
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  prf_pkg::in_beat_t          in_data_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output prf_pkg::out_beat_t         out_data_o,
  input  logic                       cfg_we_i,
  input  logic [prf_pkg::CNT_W-1:0]  cfg_wdata_i
);
  import prf_pkg::*;

  localparam int unsigned SZ_W = $clog2(MAX_ELEMENTS + 1);

  logic [SZ_W-1:0] ec_q, ec_d;
  logic            out_valid_q, out_valid_d;
  out_beat_t       out_data_q;
  logic            seq_idle, res_valid, slot_free, start;
  out_beat_t       res;
  logic [31:0]     cfg_ext;

  assign cfg_ext = 32'(cfg_wdata_i);

  // saturate element_count into its legal range
  always_comb begin
    ec_d = ec_q;
    if (cfg_we_i) begin
      if (cfg_ext == 32'd0) ec_d = SZ_W'(1);
      else if (cfg_ext > MAX_ELEMENTS) ec_d = SZ_W'(MAX_ELEMENTS);
      else ec_d = cfg_ext[SZ_W-1:0];
    end
  end

  assign slot_free  = !out_valid_q || !out_stall_i;
  assign in_stall_o = !seq_idle;
  assign start      = in_valid_i && seq_idle;

  // hold the result until the beat is taken
  always_comb begin
    out_valid_d = out_valid_q && out_stall_i;
    if (res_valid && slot_free) out_valid_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ec_q        <= SZ_W'(MAX_ELEMENTS);
      out_valid_q <= 1'b0;
    end else begin
      ec_q        <= ec_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid && slot_free) out_data_q <= res;
  end

  prf_seq #(
    .MAX_ELEMENTS(MAX_ELEMENTS),
    .MAX_BLOCKS  (MAX_BLOCKS)
  ) u_seq (
    .clk_i,
    .rst_ni,
    .start_i        (start),
    .item_i         (in_data_i),
    .element_count_i(ec_q),
    .slot_free_i    (slot_free),
    .idle_o         (seq_idle),
    .res_valid_o    (res_valid),
    .res_o          (res)
  );

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  // an accepted beat makes the block busy
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("block ready right after accepting a beat");

  // the partition always has at least one block
  a_count_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.block_count != '0))
    else $error("zero block count");

  // unknown elements report block zero
  a_unknown_block: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.status == ST_UNKNOWN) |-> (out_data_o.new_block == '0))
    else $error("unknown element with nonzero block");

  // a result is only loaded while the block is not idle
  a_result_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ($rose(out_valid_o)) |-> $past(in_stall_o))
    else $error("result appeared from idle sequencer");

endmodule

FILE: rtl/core/prf_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Standalone; used for every table of the partition refinement block.
module prf_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    rdata_o <= mem_q[raddr_i];
  end

endmodule

FILE: rtl/core/prf_seq.sv
// Partition refinement sequencer: tables in RAMs, one state machine with separate counters.
// Depends on prf_pkg and prf_ram.
module prf_seq #(
  parameter int unsigned MAX_ELEMENTS = prf_pkg::DEF_MAX_ELEMENTS,
  parameter int unsigned MAX_BLOCKS   = prf_pkg::DEF_MAX_BLOCKS
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 start_i,
  input  prf_pkg::in_beat_t                    item_i,
  input  logic [$clog2(MAX_ELEMENTS+1)-1:0]    element_count_i,
  input  logic                                 slot_free_i,
  output logic                                 idle_o,
  output logic                                 res_valid_o,
  output prf_pkg::out_beat_t                   res_o
);
  import prf_pkg::*;

  localparam int unsigned EIDX_W = $clog2(MAX_ELEMENTS);
  localparam int unsigned BIDX_W = $clog2(MAX_BLOCKS);
  localparam int unsigned SZ_W   = $clog2(MAX_ELEMENTS + 1);
  localparam int unsigned TC_W   = $clog2(MAX_BLOCKS + 1);
  localparam int unsigned CLR_N  = (MAX_ELEMENTS > MAX_BLOCKS) ? MAX_ELEMENTS : MAX_BLOCKS;
  localparam int unsigned CLR_W  = $clog2(CLR_N);

  seq_state_e state_q, state_d;

  logic [SZ_W-1:0]   member_q, member_d;
  logic [CLR_W-1:0]  clr_q, clr_d;
  logic [EIDX_W-1:0] e_q, e_d;
  logic              last_q, last_d;
  logic [BIDX_W-1:0] b_q, b_d;
  logic [BIDX_W-1:0] s_q, s_d;
  logic [SZ_W-1:0]   sb_q, sb_d;
  logic [TC_W-1:0]   scan_q, scan_d;
  logic [TC_W-1:0]   lo_q, lo_d;
  logic [TC_W-1:0]   tc_q, tc_d;
  logic [TC_W-1:0]   ci_q, ci_d;
  logic [BIDX_W-1:0] cb_q, cb_d;
  logic [TC_W-1:0]   ne_q, ne_d;
  logic [BIDX_W-1:0] nb_q, nb_d;
  status_e           status_q, status_d;
  logic              reply_q, reply_d;

  // RAM ports
  logic              boe_we;
  logic [EIDX_W-1:0] boe_wa, boe_ra;
  logic [BIDX_W-1:0] boe_wd, boe_rd;
  logic              sz_we;
  logic [BIDX_W-1:0] sz_wa, sz_ra;
  logic [SZ_W-1:0]   sz_wd, sz_rd;
  logic              st_we;
  logic [BIDX_W-1:0] st_wa, st_ra, st_wd, st_rd;
  logic              sv_we;
  logic [BIDX_W-1:0] sv_wa, sv_ra;
  logic              sv_wd, sv_rd;
  logic              tl_we;
  logic [BIDX_W-1:0] tl_wa, tl_ra, tl_wd, tl_rd;
  logic              iu_we;
  logic [BIDX_W-1:0] iu_wa, iu_ra;
  logic              iu_wd, iu_rd;

  logic [31:0] e_ext, ne_ext, nb_ext, clr_ext, cnt_ext;
  logic [TC_W-1:0] ne_dec;

  prf_ram #(.WIDTH(BIDX_W), .DEPTH(MAX_ELEMENTS)) u_boe (
    .clk_i, .we_i(boe_we), .waddr_i(boe_wa), .wdata_i(boe_wd), .raddr_i(boe_ra),
    .rdata_o(boe_rd));
  prf_ram #(.WIDTH(SZ_W), .DEPTH(MAX_BLOCKS)) u_size (
    .clk_i, .we_i(sz_we), .waddr_i(sz_wa), .wdata_i(sz_wd), .raddr_i(sz_ra),
    .rdata_o(sz_rd));
  prf_ram #(.WIDTH(BIDX_W), .DEPTH(MAX_BLOCKS)) u_split (
    .clk_i, .we_i(st_we), .waddr_i(st_wa), .wdata_i(st_wd), .raddr_i(st_ra),
    .rdata_o(st_rd));
  prf_ram #(.WIDTH(1), .DEPTH(MAX_BLOCKS)) u_split_vld (
    .clk_i, .we_i(sv_we), .waddr_i(sv_wa), .wdata_i(sv_wd), .raddr_i(sv_ra),
    .rdata_o(sv_rd));
  prf_ram #(.WIDTH(BIDX_W), .DEPTH(MAX_BLOCKS)) u_touched (
    .clk_i, .we_i(tl_we), .waddr_i(tl_wa), .wdata_i(tl_wd), .raddr_i(tl_ra),
    .rdata_o(tl_rd));
  prf_ram #(.WIDTH(1), .DEPTH(MAX_BLOCKS)) u_in_use (
    .clk_i, .we_i(iu_we), .waddr_i(iu_wa), .wdata_i(iu_wd), .raddr_i(iu_ra),
    .rdata_o(iu_rd));

  // state and datapath registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_CLEAR;
      member_q <= SZ_W'(MAX_ELEMENTS);
      clr_q    <= '0;
      reply_q  <= 1'b0;
      tc_q     <= '0;
      lo_q     <= TC_W'(1);
      ne_q     <= TC_W'(1);
    end else begin
      state_q  <= state_d;
      member_q <= member_d;
      clr_q    <= clr_d;
      reply_q  <= reply_d;
      tc_q     <= tc_d;
      lo_q     <= lo_d;
      ne_q     <= ne_d;
    end
  end

  always_ff @(posedge clk_i) begin
    e_q      <= e_d;
    last_q   <= last_d;
    b_q      <= b_d;
    s_q      <= s_d;
    sb_q     <= sb_d;
    scan_q   <= scan_d;
    ci_q     <= ci_d;
    cb_q     <= cb_d;
    nb_q     <= nb_d;
    status_q <= status_d;
  end

  assign e_ext   = 32'(item_i.element);
  assign ne_ext  = 32'(ne_q);
  assign nb_ext  = 32'(nb_q);
  assign clr_ext = 32'(clr_q);
  assign cnt_ext = 32'(sz_rd);
  assign ne_dec  = (ne_q != '0) ? ne_q - TC_W'(1) : ne_q;

  assign idle_o      = (state_q == S_IDLE);
  assign res_valid_o = (state_q == S_DONE);
  assign res_o.new_block   = nb_ext[NB_W-1:0];
  assign res_o.block_count = ne_ext[CNT_W-1:0];
  assign res_o.status      = status_q;

  // next state, table accesses
  always_comb begin
    state_d  = state_q;
    member_d = member_q;
    clr_d    = clr_q;
    e_d      = e_q;
    last_d   = last_q;
    b_d      = b_q;
    s_d      = s_q;
    sb_d     = sb_q;
    scan_d   = scan_q;
    lo_d     = lo_q;
    tc_d     = tc_q;
    ci_d     = ci_q;
    cb_d     = cb_q;
    ne_d     = ne_q;
    nb_d     = nb_q;
    status_d = status_q;
    reply_d  = reply_q;
    boe_we = 1'b0; boe_wa = '0; boe_wd = '0; boe_ra = '0;
    sz_we  = 1'b0; sz_wa  = '0; sz_wd  = '0; sz_ra  = '0;
    st_we  = 1'b0; st_wa  = '0; st_wd  = '0; st_ra  = '0;
    sv_we  = 1'b0; sv_wa  = '0; sv_wd  = 1'b0; sv_ra = '0;
    tl_we  = 1'b0; tl_wa  = '0; tl_wd  = '0; tl_ra  = '0;
    iu_we  = 1'b0; iu_wa  = '0; iu_wd  = 1'b0; iu_ra = '0;

    case (state_q)
      S_IDLE: begin
        if (start_i) begin
          last_d = item_i.last;
          e_d    = e_ext[EIDX_W-1:0];
          if (item_i.req_type == REQ_RESET) begin
            member_d = element_count_i;
            clr_d    = '0;
            reply_d  = 1'b1;
            state_d  = S_CLEAR;
          end else if (e_ext >= 32'(member_q) || e_ext >= MAX_ELEMENTS) begin
            status_d = ST_UNKNOWN;
            nb_d     = '0;
            state_d  = S_LAST;
          end else begin
            status_d = ST_OK;
            boe_ra   = e_ext[EIDX_W-1:0];
            state_d  = S_RD_B;
          end
        end
      end

      // sweep the element, size, split-valid and in-use tables back to one block
      S_CLEAR: begin
        if (clr_ext < MAX_ELEMENTS) begin
          boe_we = 1'b1;
          boe_wa = clr_q[EIDX_W-1:0];
        end
        if (clr_ext < MAX_BLOCKS) begin
          sz_we = 1'b1;
          sz_wa = clr_q[BIDX_W-1:0];
          sz_wd = (clr_q == '0) ? member_q : '0;
          sv_we = 1'b1;
          sv_wa = clr_q[BIDX_W-1:0];
          iu_we = 1'b1;
          iu_wa = clr_q[BIDX_W-1:0];
          iu_wd = (clr_q == '0);
        end
        if (clr_ext == CLR_N - 1) begin
          ne_d     = TC_W'(1);
          tc_d     = '0;
          lo_d     = TC_W'(1);
          nb_d     = '0;
          status_d = ST_OK;
          state_d  = reply_q ? S_DONE : S_IDLE;
        end else begin
          clr_d = clr_q + CLR_W'(1);
        end
      end

      S_RD_B: begin
        b_d   = boe_rd;
        sv_ra = boe_rd;
        st_ra = boe_rd;
        sz_ra = boe_rd;
        state_d = S_RD_S;
      end

      S_RD_S: begin
        sb_d = sz_rd;
        if (sv_rd) begin
          s_d     = st_rd;
          state_d = S_MV_RD;
        end else if (tc_q >= TC_W'(MAX_BLOCKS) || lo_q >= TC_W'(MAX_BLOCKS)) begin
          status_d = ST_NOFREE;
          nb_d     = b_q;
          state_d  = S_LAST;
        end else begin
          scan_d  = lo_q;
          state_d = S_SCAN_RD;
        end
      end

      // search upward for the lowest free block id
      S_SCAN_RD: begin
        if (scan_q >= TC_W'(MAX_BLOCKS)) begin
          status_d = ST_NOFREE;
          nb_d     = b_q;
          state_d  = S_LAST;
        end else begin
          iu_ra   = scan_q[BIDX_W-1:0];
          state_d = S_SCAN_CHK;
        end
      end

      S_SCAN_CHK: begin
        if (!iu_rd) begin
          state_d = S_ALLOC;
        end else begin
          scan_d  = scan_q + TC_W'(1);
          state_d = S_SCAN_RD;
        end
      end

      // claim the block and link it as split of b
      S_ALLOC: begin
        iu_we = 1'b1;
        iu_wa = scan_q[BIDX_W-1:0];
        iu_wd = 1'b1;
        st_we = 1'b1;
        st_wa = b_q;
        st_wd = scan_q[BIDX_W-1:0];
        sv_we = 1'b1;
        sv_wa = b_q;
        sv_wd = 1'b1;
        tl_we = 1'b1;
        tl_wa = tc_q[BIDX_W-1:0];
        tl_wd = b_q;
        tc_d  = tc_q + TC_W'(1);
        lo_d  = scan_q + TC_W'(1);
        s_d   = scan_q[BIDX_W-1:0];
        state_d = S_MV_RD;
      end

      S_MV_RD: begin
        sz_ra   = s_q;
        state_d = S_MV_B;
      end

      // shrink the old block
      S_MV_B: begin
        ne_d = ne_q;
        if (sb_q != '0) begin
          sz_we = 1'b1;
          sz_wa = b_q;
          sz_wd = sb_q - SZ_W'(1);
          if (sb_q == SZ_W'(1)) ne_d = ne_dec;
        end
        if (sz_rd == '0) ne_d = ne_d + TC_W'(1);
        sb_d    = sz_rd;
        state_d = S_MV_S;
      end

      // grow the split block and move the element
      S_MV_S: begin
        sz_we  = 1'b1;
        sz_wa  = s_q;
        sz_wd  = sb_q + SZ_W'(1);
        boe_we = 1'b1;
        boe_wa = e_q;
        boe_wd = s_q;
        nb_d   = s_q;
        state_d = S_LAST;
      end

      S_LAST: begin
        ci_d = '0;
        if (!last_q) begin
          state_d = S_DONE;
        end else if (tc_q == '0) begin
          state_d = S_DONE;
        end else begin
          state_d = S_CL_RD;
        end
      end

      // walk touched blocks
      S_CL_RD: begin
        tl_ra   = ci_q[BIDX_W-1:0];
        state_d = S_CL_B;
      end

      S_CL_B: begin
        cb_d    = tl_rd;
        sz_ra   = tl_rd;
        iu_ra   = tl_rd;
        state_d = S_CL_WR;
      end

      S_CL_WR: begin
        if (cnt_ext == 32'd0 && iu_rd) begin
          iu_we = 1'b1;
          iu_wa = cb_q;
          iu_wd = 1'b0;
          if (TC_W'(cb_q) < lo_q) lo_d = TC_W'(cb_q);
        end
        sv_we = 1'b1;
        sv_wa = cb_q;
        sv_wd = 1'b0;
        ci_d  = ci_q + TC_W'(1);
        if (ci_q + TC_W'(1) >= tc_q) begin
          tc_d    = '0;
          state_d = S_DONE;
        end else begin
          state_d = S_CL_RD;
        end
      end

      S_DONE: begin
        if (slot_free_i) begin
          reply_d = 1'b0;
          state_d = S_IDLE;
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

endmodule

FILE: dv/partition_refinement_top_tb.sv
// Testbench for partition_refinement_top: directed and random beats, scoreboard check.
// Depends on prf_pkg and the partition_refinement_top RTL.
module partition_refinement_top_tb;
  import prf_pkg::*;

  localparam int unsigned NELEM = 1024;
  localparam int unsigned NBLK  = 1024;
  localparam int unsigned QUIET_LIMIT = 40000;

  // Scoreboard: partition predictor plus queue of expected result beats
  class partition_scoreboard;
    int unsigned elem_cfg;
    int unsigned members;
    int unsigned blk_of[NELEM];
    int unsigned blk_size[NBLK];
    int unsigned split_to[NBLK];
    bit          split_ok[NBLK];
    int unsigned touched[NBLK];
    int unsigned touched_n;
    bit          in_use[NBLK];
    int unsigned live_blocks;
    out_beat_t   pending[$];
    int unsigned errors;

    function new();
      elem_cfg = NELEM;
      errors = 0;
      rebuild();
    endfunction

    function void rebuild();
      members = elem_cfg;
      foreach (blk_of[i]) blk_of[i] = 0;
      for (int i = 0; i < NBLK; i++) begin
        blk_size[i] = 0;
        split_ok[i] = 0;
        split_to[i] = 0;
        in_use[i] = 0;
      end
      blk_size[0] = members;
      in_use[0] = 1;
      touched_n = 0;
      live_blocks = 1;
    endfunction

    function void set_count(logic [CNT_W-1:0] v);
      int unsigned x;
      x = 32'(v);
      if (x < 1) x = 1;
      if (x > NELEM) x = NELEM;
      elem_cfg = x;
    endfunction

    // Append one expected result beat
    function void add_expected(out_beat_t o);
      pending = {pending, o};
    endfunction

    function void note_input(in_beat_t b);
      out_beat_t o;
      int unsigned e, blk, s, f;
      bit found;
      o = '0;
      if (b.req_type == REQ_RESET) begin
        rebuild();
        o.block_count = CNT_W'(1);
        o.status = ST_OK;
        add_expected(o);
        return;
      end
      e = 32'(b.element);
      o.status = ST_OK;
      if (e >= members) begin
        o.status = ST_UNKNOWN;
      end else begin
        blk = blk_of[e];
        if (!split_ok[blk]) begin
          found = 0;
          for (int i = 0; i < NBLK && !found; i++)
            if (!in_use[i]) begin
              found = 1;
              f = i;
            end
          if (!found || touched_n >= NBLK) begin
            o.status = ST_NOFREE;
            o.new_block = NB_W'(blk);
          end else begin
            in_use[f] = 1;
            split_to[blk] = f;
            split_ok[blk] = 1;
            touched[touched_n] = blk;
            touched_n++;
          end
        end
        if (o.status == ST_OK) begin
          s = split_to[blk];
          if (blk_size[blk] > 0) begin
            if (blk_size[blk] == 1 && live_blocks > 0) live_blocks--;
            blk_size[blk]--;
          end
          if (blk_size[s] == 0) live_blocks++;
          blk_size[s]++;
          blk_of[e] = s;
          o.new_block = NB_W'(s);
        end
      end
      // Walk touched blocks: free emptied ones and unlink every one
      if (b.last) begin
        for (int i = 0; i < touched_n; i++) begin
          blk = touched[i];
          if (blk_size[blk] == 0 && in_use[blk]) in_use[blk] = 0;
          split_ok[blk] = 0;
        end
        touched_n = 0;
      end
      o.block_count = CNT_W'(live_blocks);
      add_expected(o);
    endfunction

    task check_result(out_beat_t got);
      out_beat_t want;
      if (pending.size() == 0) begin
        report("result beat with nothing expected", got, got);
        return;
      end
      want = pending.pop_front();
      if (got.new_block !== want.new_block) report("new_block", got, want);
      if (got.block_count !== want.block_count) report("block_count", got, want);
      if (got.status !== want.status) report("status", got, want);
    endtask

    task report(string what, out_beat_t got, out_beat_t want);
      errors++;
      $display("mismatch %s: got nb=%0d cnt=%0d st=%0d want nb=%0d cnt=%0d st=%0d",
               what, got.new_block, got.block_count, got.status,
               want.new_block, want.block_count, want.status);
    endtask
  endclass

  logic               clk_i;
  logic               rst_ni;
  logic               in_valid_i;
  logic               in_stall_o;
  in_beat_t           in_data_i;
  logic               out_valid_o;
  logic               out_stall_i;
  out_beat_t          out_data_o;
  logic               cfg_we_i;
  logic [CNT_W-1:0]   cfg_wdata_i;

  partition_refinement_top dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i)
  );

  partition_scoreboard sb = new();
  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;
  bit          hold_off;
  bit          timed_out = 1'b0;
  int unsigned quiet_cycles = 0;
  int unsigned cur_count;

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Check result beats and count quiet cycles at the rising edge
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) sb.check_result(out_data_o);
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
  end

  always @(posedge clk_i) begin
    if (quiet_cycles >= QUIET_LIMIT && !timed_out) begin
      timed_out = 1;
      $display("tb: failure");
      $finish;
    end
  end

  // Drive receiver stall at the falling edge
  always @(negedge clk_i) begin
    if (!rst_ni) out_stall_i <= 1'b0;
    else if (hold_off) out_stall_i <= 1'b1;
    else out_stall_i <= ($urandom_range(99) < recv_idle_pct);
  end

  // Offer one beat, with random gaps, and hold it until accepted; the next call
  // or an explicit drop clears valid at the falling edge where this returns
  task automatic send_beat(in_beat_t b);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i <= b;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    sb.note_input(b);
    @(negedge clk_i);
  endtask

  task automatic send_refine(int unsigned e, bit lst);
    in_beat_t b;
    b.req_type = REQ_REFINE;
    b.element = ELEM_W'(e);
    b.last = lst;
    send_beat(b);
  endtask

  task automatic send_reset();
    in_beat_t b;
    b.req_type = REQ_RESET;
    b.element = ELEM_W'($urandom);
    b.last = 1'($urandom);
    send_beat(b);
  endtask

  // Wait for the block to drain, then write element_count
  task automatic write_count(logic [CNT_W-1:0] v);
    int unsigned guard;
    guard = 0;
    in_valid_i <= 1'b0;
    while (sb.pending.size() != 0 && guard < 200000) begin
      @(negedge clk_i);
      guard++;
    end
    repeat (3000) @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= v;
    sb.set_count(v);
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    cur_count = sb.elem_cfg;
  endtask

  // Random phase: well-formed sets over the current members plus noise
  task automatic random_phase(int unsigned n_items);
    int unsigned sent, len;
    sent = 0;
    while (sent < n_items) begin
      if ($urandom_range(99) < 4) begin
        send_reset();
        sent++;
      end else begin
        len = $urandom_range(1, 8);
        for (int i = 0; i < len; i++) begin
          if ($urandom_range(99) < 8) send_refine($urandom_range(1023), i == len - 1);
          else send_refine($urandom_range(cur_count - 1), i == len - 1);
          sent++;
        end
      end
    end
  endtask

  initial begin
    int unsigned guard;
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    in_data_i = '0;
    cfg_we_i = 1'b0;
    cfg_wdata_i = '0;
    hold_off = 0;
    send_idle_pct = 19;
    recv_idle_pct = 48;
    cur_count = NELEM;
    repeat (11) @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed: extremes, unknown elements, repeats, last with error
    send_refine(0, 0);
    send_refine(1023, 0);
    send_refine(0, 0);
    send_refine(512, 1);
    send_refine(341, 1);
    send_refine(682, 1);
    send_reset();
    write_count(11'd0);
    send_reset();
    send_refine(0, 0);
    send_refine(1, 1);
    send_refine(1023, 1);
    send_refine(0, 1);
    write_count(11'h7FF);
    send_reset();
    write_count(11'd5);
    send_refine(3, 0);
    send_reset();
    send_refine(4, 0);
    send_refine(5, 1);
    send_refine(4, 1);
    send_refine(2, 0);
    send_refine(2, 1);

    // Long receiver hold-off while the sender keeps offering
    fork
      begin
        hold_off = 1;
        repeat (400) @(negedge clk_i);
        hold_off = 0;
      end
      begin
        random_phase(10);
        in_valid_i <= 1'b0;
      end
    join

    random_phase(250);
    write_count(11'd40);
    send_reset();
    send_idle_pct = 48;
    recv_idle_pct = 19;
    random_phase(250);
    write_count(11'd1024);
    send_reset();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    random_phase(280);

    in_valid_i <= 1'b0;
    guard = 0;
    while (sb.pending.size() != 0 && guard < 200000) begin
      @(negedge clk_i);
      guard++;
    end
    repeat (200) @(negedge clk_i);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end
endmodule
